// ----- sv/bslu_pkg.sv -----
package bslu_pkg;

    // Geometry of the state and of one pipeline beat.
    localparam int STATE_BYTES = 16;
    localparam int STATE_W     = 8 * STATE_BYTES;
    localparam int HALF_W      = STATE_W / 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 2;

    // One pipeline stage per butterfly layer.
    localparam int STAGES      = 4;

    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t REG_ROTOR_ENABLE    = 2'd0;
    localparam cfg_index_t REG_ROUND_PHASE     = 2'd1;
    localparam cfg_index_t REG_OUTER_KEEP_MASK = 2'd2;

    // Reset values of the configuration registers.
    localparam logic       ROTOR_ENABLE_RST    = 1'b0;
    localparam logic [1:0] ROUND_PHASE_RST     = 2'd0;
    localparam logic [7:0] OUTER_KEEP_MASK_RST = 8'hFF;

    // An 8x8 bit matrix, row 0 in bits 63:56; row r gives output bit 7-r
    // and column c of a row is bit 7-c of that row byte.
    typedef logic [63:0] mat_t;

    typedef struct packed {
        logic       rotor_enable;
        logic [1:0] round_phase;
        logic [7:0] outer_keep_mask;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               inverse;
    } beat_t;

    localparam mat_t BASE_MAT = 64'hC873_F514_01C0_DE82;

    // Clockwise rotation: new[r][c] = old[7-c][r].
    function automatic mat_t mat_rotate(mat_t src);
        mat_t dst;
        dst = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                dst[56 - 8 * r + (7 - c)] = src[56 - 8 * (7 - c) + (7 - r)];
            end
        end
        return dst;
    endfunction

    localparam mat_t MAT_1 = mat_rotate(BASE_MAT);
    localparam mat_t MAT_2 = mat_rotate(MAT_1);
    localparam mat_t MAT_3 = mat_rotate(MAT_2);

    function automatic mat_t mat_sel(logic [1:0] k);
        mat_t m;
        case (k)
            2'd0:    m = BASE_MAT;
            2'd1:    m = MAT_1;
            2'd2:    m = MAT_2;
            default: m = MAT_3;
        endcase
        return m;
    endfunction

    // Matrix times byte over GF(2): each output bit is the parity of a row and x.
    function automatic logic [7:0] mat_apply(mat_t m, logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[7 - i] = ^(m[63 - 8 * i -: 8] & x);
        end
        return y;
    endfunction

    // Butterfly layer, distance 2**s, over eight disjoint pairs; mask-gated at 8.
    function automatic logic [STATE_W-1:0] butterfly_layer(
        logic [STATE_W-1:0] st,
        logic [1:0]         s,
        cfg_t               cfg
    );
        logic [7:0]         b [STATE_BYTES];
        logic [3:0]         d;
        logic [3:0]         lo4;
        logic [3:0]         hi;
        logic [2:0]         pidx;
        logic [1:0]         k;
        logic [7:0]         l;
        logic [7:0]         h;
        logic               run;
        logic [STATE_W-1:0] res;
        for (int i = 0; i < STATE_BYTES; i++) begin
            b[i] = st[STATE_W - 1 - 8 * i -: 8];
        end
        d = 4'd1 << s;
        for (int lo = 0; lo < STATE_BYTES; lo++) begin
            lo4 = 4'(lo);
            if ((lo4 & d) == 4'd0) begin
                hi   = lo4 | d;
                // Pair number: the byte index with bit s squeezed out.
                pidx = 3'(((lo4 >> (3'(s) + 3'd1)) << s) | (lo4 & (d - 4'd1)));
                run  = !((s == 2'd3) && !cfg.outer_keep_mask[pidx]);
                k    = cfg.rotor_enable ?
                       2'(3'(cfg.round_phase) + 3'(s) + pidx) : 2'd0;
                l = b[lo4];
                h = b[hi];
                if (run) begin
                    l = l ^ mat_apply(mat_sel(k), h);
                    h = h ^ mat_apply(mat_sel(k ^ 2'd1), l);
                    l = l ^ mat_apply(mat_sel(k), h);
                end
                b[lo4] = l;
                b[hi] = h;
            end
        end
        for (int i = 0; i < STATE_BYTES; i++) begin
            res[STATE_W - 1 - 8 * i -: 8] = b[i];
        end
        return res;
    endfunction

endpackage

// ----- sv/bslu_in_if.sv -----
interface bslu_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] state_high;
    logic [63:0] state_low;
    logic        inverse_direction;

    modport source (
        output valid,
        output state_high,
        output state_low,
        output inverse_direction,
        input  ready
    );

    modport sink (
        input  valid,
        input  state_high,
        input  state_low,
        input  inverse_direction,
        output ready
    );
endinterface

// ----- sv/bslu_out_if.sv -----
interface bslu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (
        output valid,
        output result_high,
        output result_low,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_high,
        input  result_low,
        output ready
    );
endinterface

// ----- sv/bslu_stage.sv -----
module bslu_stage
    import bslu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] stage_idx,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  beat_t      in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output beat_t      out_beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    beat_t beat_next;
    logic  [1:0] layer_sel;
    logic  load;

    // The inverse direction walks the layers from distance 8 down to 1.
    assign layer_sel = in_beat.inverse ? ~stage_idx : stage_idx;

    // The stage register may take a new beat when empty or draining.
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        beat_next.state   = butterfly_layer(in_beat.state, layer_sel, cfg);
        beat_next.inverse = in_beat.inverse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- sv/butterfly_shear_linear_layer_unit.sv -----
// Pipeline: four register stages, one butterfly layer per stage; a beat moves
// through them in order and the last one drives the output channel.
// Throughput: one 128-bit block per cycle while the output is not stalled.
// A stalled output holds the pipeline in place and back-pressures the input.
// Reset clears the stage valid bits and loads the configuration defaults
// (rotor off, round phase 0, keep mask all ones).
module butterfly_shear_linear_layer_unit
    import bslu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cfg_index_t      wr_index,
    input  cfg_data_t       wr_data,
    bslu_in_if.sink         in_ch,
    bslu_out_if.source      out_ch
);

    logic       rotor_enable_reg;
    logic       rotor_enable_next;
    logic [1:0] round_phase_reg;
    logic [1:0] round_phase_next;
    logic [7:0] outer_keep_mask_reg;
    logic [7:0] outer_keep_mask_next;
    cfg_t       cfg;

    logic  link_valid [STAGES + 1];
    logic  link_ready [STAGES + 1];
    beat_t link_beat  [STAGES + 1];

    // Configuration register decode.
    always_comb
    begin
        rotor_enable_next    = rotor_enable_reg;
        round_phase_next     = round_phase_reg;
        outer_keep_mask_next = outer_keep_mask_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ROTOR_ENABLE:    rotor_enable_next    = wr_data[0];
                REG_ROUND_PHASE:     round_phase_next     = wr_data[1:0];
                REG_OUTER_KEEP_MASK: outer_keep_mask_next = wr_data[7:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_enable_reg    <= ROTOR_ENABLE_RST;
            round_phase_reg     <= ROUND_PHASE_RST;
            outer_keep_mask_reg <= OUTER_KEEP_MASK_RST;
        end
        else
        begin
            rotor_enable_reg    <= rotor_enable_next;
            round_phase_reg     <= round_phase_next;
            outer_keep_mask_reg <= outer_keep_mask_next;
        end
    end

    assign cfg.rotor_enable    = rotor_enable_reg;
    assign cfg.round_phase     = round_phase_reg;
    assign cfg.outer_keep_mask = outer_keep_mask_reg;

    // Input beat into the head of the pipeline.
    assign link_valid[0]        = in_ch.valid;
    assign in_ch.ready          = link_ready[0];
    assign link_beat[0].state   = {in_ch.state_high, in_ch.state_low};
    assign link_beat[0].inverse = in_ch.inverse_direction;

    // One registered stage per butterfly layer.
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        bslu_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (2'(g)),
            .cfg       (cfg),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_beat   (link_beat[g]),
            .out_valid (link_valid[g + 1]),
            .out_ready (link_ready[g + 1]),
            .out_beat  (link_beat[g + 1])
        );
    end

    // The last stage register drives the result channel directly.
    assign out_ch.valid        = link_valid[STAGES];
    assign link_ready[STAGES]  = out_ch.ready;
    assign out_ch.result_high  = link_beat[STAGES].state[STATE_W-1:HALF_W];
    assign out_ch.result_low   = link_beat[STAGES].state[HALF_W-1:0];

endmodule
